// ===== sv/csab_pkg.sv =====
`default_nettype none
package csab_pkg;

   localparam int SCREEN_DIM_MAX = 4096;
   localparam int DIM_W          = $clog2(SCREEN_DIM_MAX) + 1;
   localparam int COORD_W        = $clog2(SCREEN_DIM_MAX);
   localparam int PROD_W         = COORD_W + DIM_W;
   localparam int ADDR_W         = 24;
   localparam int CHAN_W         = 8;
   localparam int NUM_CHAN       = 3;
   localparam int PIX_W          = CHAN_W * NUM_CHAN;
   localparam int ARGB_W         = 32;

   typedef enum logic [2:0] {
      REG_LAYER_ENABLE  = 3'd0,
      REG_SPRITE_LEFT   = 3'd1,
      REG_SPRITE_TOP    = 3'd2,
      REG_SPRITE_WIDTH  = 3'd3,
      REG_SPRITE_HEIGHT = 3'd4,
      REG_SCREEN_WIDTH  = 3'd5,
      REG_SCREEN_HEIGHT = 3'd6
   } csab_reg_type;

   // Load enables for the second and third pipeline stages.
   typedef struct packed {
      logic en2;
      logic en3;
   } csab_adv_type;

   typedef struct packed {
      logic [COORD_W-1:0] tx;
      logic [COORD_W-1:0] ty;
      logic [DIM_W-1:0]   stride;
   } csab_coord_type;

   typedef struct packed {
      logic [ARGB_W-1:0] src;
      logic [PIX_W-1:0]  dst;
   } csab_colour_type;

endpackage
`default_nettype wire

// ===== sv/csab_addr.sv =====
`default_nettype none
module csab_addr
   import csab_pkg::*;
(
   input  wire logic           clock,
   input  csab_adv_type        adv,
   input  csab_coord_type      coord,
   output logic [ADDR_W-1:0]   target_address
);

   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [COORD_W-1:0] tx_ff;
   logic [ADDR_W-1:0]  addr_ff, addr_in;

   // Row times stride here, column added a stage later.
   assign prod_in = PROD_W'(coord.ty * coord.stride);
   assign addr_in = ADDR_W'(prod_ff + PROD_W'(tx_ff));

   always_ff @(posedge clock) begin
      if (adv.en2) begin
         prod_ff <= prod_in;
         tx_ff   <= coord.tx;
      end
      if (adv.en3) begin
         addr_ff <= addr_in;
      end
   end

   assign target_address = addr_ff;

endmodule
`default_nettype wire

// ===== sv/csab_mix.sv =====
`default_nettype none
module csab_mix
   import csab_pkg::*;
(
   input  wire logic          clock,
   input  csab_adv_type       adv,
   input  csab_colour_type    colour,
   output logic [PIX_W-1:0]   blended_pixel
);

   localparam int DPROD_W = 2 * CHAN_W + 1;
   localparam int SPROD_W = 2 * CHAN_W;

   logic [CHAN_W-1:0]  alpha;
   logic [CHAN_W:0]    inv_alpha;
   logic               opaque_ff, opaque_in;
   logic [PIX_W-1:0]   copy_ff;
   logic [DPROD_W-1:0] pd_ff [NUM_CHAN];
   logic [DPROD_W-1:0] pd_in [NUM_CHAN];
   logic [SPROD_W-1:0] ps_ff [NUM_CHAN];
   logic [SPROD_W-1:0] ps_in [NUM_CHAN];
   logic [PIX_W-1:0]   mix_in;
   logic [PIX_W-1:0]   pix_ff, pix_in;

   assign alpha     = colour.src[ARGB_W-1 -: CHAN_W];
   assign inv_alpha = (CHAN_W+1)'(1 << CHAN_W) - {1'b0, alpha};
   assign opaque_in = (alpha == {CHAN_W{1'b1}});

   for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
      logic [DPROD_W-1:0] sum;
      assign pd_in[c] = DPROD_W'(colour.dst[c*CHAN_W +: CHAN_W] * inv_alpha);
      assign ps_in[c] = SPROD_W'(colour.src[c*CHAN_W +: CHAN_W] * alpha);
      // Below full opacity the sum stays under 2^16, so take bits 15:8.
      assign sum = pd_ff[c] + DPROD_W'(ps_ff[c]);
      assign mix_in[c*CHAN_W +: CHAN_W] = sum[2*CHAN_W-1:CHAN_W];

      always_ff @(posedge clock) begin
         if (adv.en2) begin
            pd_ff[c] <= pd_in[c];
            ps_ff[c] <= ps_in[c];
         end
      end
   end

   assign pix_in = opaque_ff ? copy_ff : mix_in;

   always_ff @(posedge clock) begin
      if (adv.en2) begin
         opaque_ff <= opaque_in;
         copy_ff   <= colour.src[PIX_W-1:0];
      end
      if (adv.en3) begin
         pix_ff <= pix_in;
      end
   end

   assign blended_pixel = pix_ff;

endmodule
`default_nettype wire

// ===== sv/clipped_sprite_alpha_blender_unit.sv =====
`default_nettype none
// Sprite blitter back end: every accepted transaction carries one ARGB sprite
// pixel, its column and row inside the sprite and the back-buffer pixel at its
// target. Pixels outside the sprite, off screen, with alpha 0 or sent while
// the layer is disabled are dropped at the input; the rest leave through the
// three register stages (clip and capture, multiply, sum and select), the last
// of which is the output register, with the screen address (row times screen
// width plus column) and the blended RGB value. One transaction is taken every
// cycle unless the output is held off by rsp_tready. Registers sit at
// byte addresses 0x00 to 0x18 and must only be written while the pipeline is
// empty. Sizes above 256 (sprite) or 4096 (screen) act as those limits.
module clipped_sprite_alpha_blender_unit
   import csab_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // source_pixel[31:0], backdrop_pixel[63:32], sprite_column[71:64],
   // sprite_row[79:72]
   input  wire logic [79:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // target_address[23:0], blended_pixel[47:24]
   output logic [47:0]      rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic              layer_enable_ff;
   logic [12:0]       sprite_left_ff;
   logic [12:0]       sprite_top_ff;
   logic [8:0]        sprite_width_ff;
   logic [8:0]        sprite_height_ff;
   logic [DIM_W-1:0]  screen_width_ff;
   logic [DIM_W-1:0]  screen_height_ff;
   csab_reg_type      reg_sel;
   logic              cfg_write;

   logic [ARGB_W-1:0] src;
   logic [ARGB_W-1:0] dst;
   logic [7:0]        col;
   logic [7:0]        row;
   logic [DIM_W-1:0]  stride_w;
   logic [DIM_W-1:0]  limit_h;
   logic [13:0]       tx_full;
   logic [13:0]       ty_full;
   logic              keep;

   logic              v1_ff, v1_in;
   logic              v2_ff, v2_in;
   logic              v3_ff, v3_in;
   logic              s1_ready, s2_ready, s3_ready;
   csab_coord_type    coord_ff, coord_in;
   csab_colour_type   colour_ff, colour_in;
   csab_adv_type      adv;
   logic [ADDR_W-1:0] target_address;
   logic [PIX_W-1:0]  blended_pixel;

   // Configuration port
   assign csr_pready = 1'b1;
   assign reg_sel    = csab_reg_type'(csr_paddr[4:2]);
   assign cfg_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_enable_ff  <= 1'b0;
         sprite_left_ff   <= '0;
         sprite_top_ff    <= '0;
         sprite_width_ff  <= '0;
         sprite_height_ff <= '0;
         screen_width_ff  <= '0;
         screen_height_ff <= '0;
      end else if (cfg_write) begin
         case (reg_sel)
            REG_LAYER_ENABLE:  layer_enable_ff  <= csr_pwdata[0];
            REG_SPRITE_LEFT:   sprite_left_ff   <= csr_pwdata[12:0];
            REG_SPRITE_TOP:    sprite_top_ff    <= csr_pwdata[12:0];
            REG_SPRITE_WIDTH:  sprite_width_ff  <= csr_pwdata[8:0];
            REG_SPRITE_HEIGHT: sprite_height_ff <= csr_pwdata[8:0];
            REG_SCREEN_WIDTH:  screen_width_ff  <= csr_pwdata[DIM_W-1:0];
            REG_SCREEN_HEIGHT: screen_height_ff <= csr_pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_LAYER_ENABLE:  csr_prdata = {31'd0, layer_enable_ff};
         REG_SPRITE_LEFT:   csr_prdata = {19'd0, sprite_left_ff};
         REG_SPRITE_TOP:    csr_prdata = {19'd0, sprite_top_ff};
         REG_SPRITE_WIDTH:  csr_prdata = {23'd0, sprite_width_ff};
         REG_SPRITE_HEIGHT: csr_prdata = {23'd0, sprite_height_ff};
         REG_SCREEN_WIDTH:  csr_prdata = 32'(screen_width_ff);
         REG_SCREEN_HEIGHT: csr_prdata = 32'(screen_height_ff);
         default:           csr_prdata = 32'd0;
      endcase
   end

   // Clip at the input
   assign src = req_tdata[31:0];
   assign dst = req_tdata[63:32];
   assign col = req_tdata[71:64];
   assign row = req_tdata[79:72];

   assign stride_w = (screen_width_ff > DIM_W'(SCREEN_DIM_MAX)) ?
                     DIM_W'(SCREEN_DIM_MAX) : screen_width_ff;
   assign limit_h  = (screen_height_ff > DIM_W'(SCREEN_DIM_MAX)) ?
                     DIM_W'(SCREEN_DIM_MAX) : screen_height_ff;

   assign tx_full = {sprite_left_ff[12], sprite_left_ff} + {6'd0, col};
   assign ty_full = {sprite_top_ff[12], sprite_top_ff} + {6'd0, row};

   // Any sprite size of 256 or more covers every 8-bit column and row.
   assign keep = layer_enable_ff
               & ({1'b0, col} < sprite_width_ff)
               & ({1'b0, row} < sprite_height_ff)
               & ~tx_full[13] & ~ty_full[13]
               & (tx_full[12:0] < stride_w)
               & (ty_full[12:0] < limit_h)
               & (src[ARGB_W-1 -: CHAN_W] != '0);

   assign coord_in.tx      = tx_full[COORD_W-1:0];
   assign coord_in.ty      = ty_full[COORD_W-1:0];
   assign coord_in.stride  = stride_w;
   assign colour_in.src    = src;
   assign colour_in.dst    = dst[PIX_W-1:0];

   // Pipeline control: each stage may load when empty or when it drains.
   assign s3_ready = ~v3_ff | rsp_tready;
   assign s2_ready = ~v2_ff | s3_ready;
   assign s1_ready = ~v1_ff | s2_ready;

   assign v1_in = s1_ready ? (req_tvalid & keep) : v1_ff;
   assign v2_in = s2_ready ? v1_ff : v2_ff;
   assign v3_in = s3_ready ? v2_ff : v3_ff;

   assign adv.en2 = s2_ready;
   assign adv.en3 = s3_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         coord_ff  <= coord_in;
         colour_ff <= colour_in;
      end
   end

   csab_addr u_addr (
      .clock          (clock),
      .adv            (adv),
      .coord          (coord_ff),
      .target_address (target_address)
   );

   csab_mix u_mix (
      .clock         (clock),
      .adv           (adv),
      .colour        (colour_ff),
      .blended_pixel (blended_pixel)
   );

   assign req_tready = s1_ready;
   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = {blended_pixel, target_address};

endmodule
`default_nettype wire

// ===== sim/tb_clipped_sprite_alpha_blender_unit.sv =====
`timescale 1ns / 100ps

module tb_clipped_sprite_alpha_blender_unit;
   import csab_pkg::*;

   localparam int          SPRITE_DIM_MAX   = 256;
   localparam logic [7:0]  ALPHA_CLEAR      = 8'h00;
   localparam logic [7:0]  ALPHA_OPAQUE     = 8'hFF;
   localparam logic [2:0]  REG_UNMAPPED     = 3'd7;
   localparam int          LONG_STALL_CYCLES = 200;

   typedef struct packed {
      logic [7:0]  row;
      logic [7:0]  col;
      logic [31:0] backdrop;
      logic [31:0] source;
   } sprite_pixel_type;

   typedef struct packed {
      logic [PIX_W-1:0]  pixel;
      logic [ADDR_W-1:0] addr;
   } frame_write_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   // source_pixel[31:0], backdrop_pixel[63:32], sprite_column[71:64],
   // sprite_row[79:72]
   logic [79:0] req_tdata = '0;
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // target_address[23:0], blended_pixel[47:24]
   wire  [47:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   wire  [31:0] csr_prdata;
   wire         csr_pready;

   clipped_sprite_alpha_blender_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   // shadow copy of the layer registers
   bit                 cfg_enable   = 1'b0;
   logic signed [12:0] cfg_left     = '0;
   logic signed [12:0] cfg_top      = '0;
   logic [8:0]         cfg_sprite_w = '0;
   logic [8:0]         cfg_sprite_h = '0;
   logic [12:0]        cfg_screen_w = '0;
   logic [12:0]        cfg_screen_h = '0;

   sprite_pixel_type pending_pixels[$];
   frame_write_type  expected_writes[$];

   int  send_gap_pct    = 17;
   int  recv_stall_pct  = 46;
   bit  long_stall_req  = 1'b0;
   bit  long_stall_done = 1'b0;
   int  stall_left      = 0;
   int  pixels_taken    = 0;
   int  writes_seen     = 0;
   int  mismatches      = 0;
   int  settings_used   = 0;

   function automatic logic [7:0] mix_channel(input logic [7:0] s, input logic [7:0] d,
                                              input logic [7:0] a);
      int v;
      v = (int'(d) * (256 - int'(a)) + int'(s) * int'(a)) >> 8;
      return v[7:0];
   endfunction

   function automatic bit blend_target(input sprite_pixel_type px, output frame_write_type w);
      int         span_x, span_y, scr_w, scr_h, tx, ty, addr;
      logic [7:0] a;
      span_x = (cfg_sprite_w > SPRITE_DIM_MAX) ? SPRITE_DIM_MAX : int'(cfg_sprite_w);
      span_y = (cfg_sprite_h > SPRITE_DIM_MAX) ? SPRITE_DIM_MAX : int'(cfg_sprite_h);
      scr_w  = (cfg_screen_w > SCREEN_DIM_MAX) ? SCREEN_DIM_MAX : int'(cfg_screen_w);
      scr_h  = (cfg_screen_h > SCREEN_DIM_MAX) ? SCREEN_DIM_MAX : int'(cfg_screen_h);
      w = '0;
      if (!cfg_enable) return 1'b0;
      if (int'(px.col) >= span_x || int'(px.row) >= span_y) return 1'b0;
      tx = int'(cfg_left) + int'(px.col);
      ty = int'(cfg_top) + int'(px.row);
      if (tx < 0 || ty < 0 || tx >= scr_w || ty >= scr_h) return 1'b0;
      a = px.source[31:24];
      if (a == ALPHA_CLEAR) return 1'b0;
      if (a == ALPHA_OPAQUE) begin
         w.pixel = px.source[23:0];
      end else begin
         w.pixel = {mix_channel(px.source[23:16], px.backdrop[23:16], a),
                    mix_channel(px.source[15:8],  px.backdrop[15:8],  a),
                    mix_channel(px.source[7:0],   px.backdrop[7:0],   a)};
      end
      addr   = ty * scr_w + tx;
      w.addr = addr[ADDR_W-1:0];
      return 1'b1;
   endfunction

   // pixel sender
   always @(posedge clock) begin : drive_pixels
      frame_write_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            pixels_taken++;
            if (blend_target(sprite_pixel_type'(req_tdata), w)) expected_writes.push_back(w);
         end
         if (!req_tvalid || req_tready) begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               req_tdata  <= pending_pixels.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // frame write receiver and checker
   always @(posedge clock) begin : check_writes
      frame_write_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = frame_write_type'(rsp_tdata);
            writes_seen++;
            if (expected_writes.size() == 0) begin
               $display("%0t: unexpected write, expected none, got addr %h pixel %h",
                        $realtime, got.addr, got.pixel);
               mismatches++;
            end else begin
               want = expected_writes.pop_front();
               if (got.addr !== want.addr) begin
                  $display("%0t: target_address expected %h, got %h",
                           $realtime, want.addr, got.addr);
                  mismatches++;
               end
               if (got.pixel !== want.pixel) begin
                  $display("%0t: blended_pixel expected %h, got %h",
                           $realtime, want.pixel, got.pixel);
                  mismatches++;
               end
            end
         end
         // hold off for a long stretch once so that the pipeline backs up
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (long_stall_req && !long_stall_done) begin
            stall_left      <= LONG_STALL_CYCLES - 1;
            long_stall_done <= 1'b1;
            rsp_tready      <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         REG_LAYER_ENABLE:  cfg_enable   = value[0];
         REG_SPRITE_LEFT:   cfg_left     = value[12:0];
         REG_SPRITE_TOP:    cfg_top      = value[12:0];
         REG_SPRITE_WIDTH:  cfg_sprite_w = value[8:0];
         REG_SPRITE_HEIGHT: cfg_sprite_h = value[8:0];
         REG_SCREEN_WIDTH:  cfg_screen_w = value[12:0];
         REG_SCREEN_HEIGHT: cfg_screen_h = value[12:0];
         default: ;
      endcase
   endtask

   // random junk above the register's field, which the block ignores
   function automatic logic [31:0] pad_high(input int v, input int bits);
      logic [31:0] mask;
      mask = (32'd1 << bits) - 32'd1;
      return (v & mask) | ($urandom & ~mask);
   endfunction

   task automatic program_layer(input bit en, input int left, input int top, input int sw,
                                input int sh, input int scw, input int sch);
      csr_write(REG_SPRITE_LEFT,   pad_high(left, 13));
      csr_write(REG_SPRITE_TOP,    pad_high(top, 13));
      csr_write(REG_SPRITE_WIDTH,  pad_high(sw, 9));
      csr_write(REG_SPRITE_HEIGHT, pad_high(sh, 9));
      csr_write(REG_SCREEN_WIDTH,  pad_high(scw, 13));
      csr_write(REG_SCREEN_HEIGHT, pad_high(sch, 13));
      csr_write(REG_LAYER_ENABLE,  pad_high(en, 1));
      settings_used++;
      @(negedge clock);
   endtask

   task automatic queue_pixel(input logic [31:0] src, input logic [31:0] dst,
                              input logic [7:0] col, input logic [7:0] row);
      sprite_pixel_type px;
      px = '{row: row, col: col, backdrop: dst, source: src};
      pending_pixels.push_back(px);
   endtask

   // mostly pixels inside the sprite, some stray coordinates
   task automatic queue_random(input int n);
      int               span_x, span_y, roll;
      sprite_pixel_type px;
      span_x = (cfg_sprite_w > SPRITE_DIM_MAX) ? SPRITE_DIM_MAX : int'(cfg_sprite_w);
      span_y = (cfg_sprite_h > SPRITE_DIM_MAX) ? SPRITE_DIM_MAX : int'(cfg_sprite_h);
      repeat (n) begin
         px.source   = $urandom;
         px.backdrop = $urandom;
         roll = $urandom_range(99);
         if (roll < 10) px.source[31:24] = ALPHA_CLEAR;
         else if (roll < 20) px.source[31:24] = ALPHA_OPAQUE;
         if (span_x > 0 && $urandom_range(99) < 85) px.col = 8'($urandom_range(span_x - 1));
         else px.col = 8'($urandom_range(255));
         if (span_y > 0 && $urandom_range(99) < 85) px.row = 8'($urandom_range(span_y - 1));
         else px.row = 8'($urandom_range(255));
         pending_pixels.push_back(px);
      end
   endtask

   // wait until every transaction has gone through, then let the pipeline empty
   task automatic drain();
      while (pending_pixels.size() != 0 || req_tvalid || expected_writes.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic random_small_layer(input int n);
      program_layer(1'b1, int'($urandom_range(80)) - 20, int'($urandom_range(80)) - 20,
                    $urandom_range(1, 64), $urandom_range(1, 64),
                    $urandom_range(64, 200), $urandom_range(64, 200));
      queue_random(n);
      drain();
   endtask

   task automatic random_wide_layer(input int n);
      program_layer($urandom_range(7) != 0, $urandom_range(8191), $urandom_range(8191),
                    $urandom_range(511), $urandom_range(511),
                    $urandom_range(8191), $urandom_range(8191));
      queue_random(n);
      drain();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // layer is still disabled out of reset
      queue_pixel(32'hFF804020, 32'h00102030, 8'd0, 8'd0);
      drain();

      program_layer(1'b1, -3, -2, 16, 8, 64, 48);
      queue_pixel(32'hFF123456, 32'hAA654321, 8'd5, 8'd4);
      queue_pixel(32'h00FFFFFF, 32'h00000000, 8'd5, 8'd4);
      queue_pixel(32'h01FFFFFF, 32'h00000000, 8'd6, 8'd4);
      queue_pixel(32'hFE000000, 32'hFFFFFFFF, 8'd7, 8'd4);
      queue_pixel(32'h80FF00FF, 32'h0000FF00, 8'd8, 8'd5);
      queue_pixel(32'h7F0F0F0F, 32'hFFF0F0F0, 8'd9, 8'd5);
      queue_pixel(32'hFFFFFFFF, 32'hFFFFFFFF, 8'd2, 8'd4);
      queue_pixel(32'hFFFFFFFF, 32'hFFFFFFFF, 8'd5, 8'd1);
      queue_pixel(32'hFFFFFFFF, 32'h00000000, 8'd3, 8'd2);
      queue_pixel(32'hC0A5A5A5, 32'h005A5A5A, 8'd15, 8'd7);
      queue_pixel(32'hFFFFFFFF, 32'h00000000, 8'd16, 8'd3);
      queue_pixel(32'hFFFFFFFF, 32'h00000000, 8'd4, 8'd8);
      queue_pixel(32'hFFFFFFFF, 32'h00000000, 8'd255, 8'd255);
      drain();

      // a write to an unmapped address must leave the layer alone
      csr_write(REG_UNMAPPED, 32'hFFFFFFFF);
      @(negedge clock);
      queue_pixel(32'h40336699, 32'h00CC9966, 8'd10, 8'd6);
      drain();

      // right and bottom screen edges
      program_layer(1'b1, 60, 44, 16, 8, 64, 48);
      queue_pixel(32'hFF010203, 32'h00000000, 8'd3, 8'd0);
      queue_pixel(32'hFF010203, 32'h00000000, 8'd4, 8'd0);
      queue_pixel(32'hFF010203, 32'h00000000, 8'd0, 8'd3);
      queue_pixel(32'hFF010203, 32'h00000000, 8'd0, 8'd4);
      drain();

      // oversized sprite and screen, last pixel of the address space
      program_layer(1'b1, 4095, 4095, 511, 511, 8191, 8191);
      queue_pixel(32'h9E123456, 32'hFF654321, 8'd0, 8'd0);
      queue_pixel(32'hFF123456, 32'h00654321, 8'd1, 8'd0);
      drain();

      program_layer(1'b1, -4096, -4096, 256, 256, 4096, 4096);
      queue_pixel(32'hFFFFFFFF, 32'h00000000, 8'd255, 8'd255);
      drain();

      // empty sprite, empty screen, disabled layer
      program_layer(1'b1, 0, 0, 0, 8, 64, 48);
      queue_pixel(32'hFFFFFFFF, 32'h00000000, 8'd0, 8'd0);
      drain();
      program_layer(1'b1, 0, 0, 8, 8, 0, 48);
      queue_pixel(32'hFFFFFFFF, 32'h00000000, 8'd0, 8'd0);
      drain();
      program_layer(1'b0, 0, 0, 8, 8, 64, 48);
      queue_pixel(32'hFFFFFFFF, 32'h00000000, 8'd0, 8'd0);
      drain();

      program_layer(1'b1, 0, 0, 256, 256, 4096, 4096);
      queue_random(120);
      drain();
      program_layer(1'b1, int'($urandom_range(80)) - 20, int'($urandom_range(80)) - 20,
                    $urandom_range(1, 64), $urandom_range(1, 64),
                    $urandom_range(64, 200), $urandom_range(64, 200));
      queue_random(120);
      long_stall_req <= 1'b1;
      drain();

      send_gap_pct   <= 46;
      recv_stall_pct <= 17;
      program_layer(1'b1, 4000, 3990, 300, 511, 8191, 8191);
      queue_random(100);
      drain();
      random_wide_layer(60);

      send_gap_pct   <= 0;
      recv_stall_pct <= 0;
      random_small_layer(120);
      program_layer(1'b1, int'($urandom_range(3900)), int'($urandom_range(3900)),
                    256, 256, 4096, 4096);
      queue_random(80);
      drain();

      $display("Covered %0d layer settings: %0d pixel transactions in, %0d frame writes out,",
               settings_used, pixels_taken, writes_seen);
      $display("with clipping on all four screen edges and one long output hold-off.");
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== clipped_sprite_alpha_blender_unit.f =====
sv/csab_pkg.sv
sv/csab_addr.sv
sv/csab_mix.sv
sv/clipped_sprite_alpha_blender_unit.sv
sim/tb_clipped_sprite_alpha_blender_unit.sv
